@@ sv/u2l9_pkg.sv @@
// Types, constants and the Latin-9 mapping shared by the UTF-8 to Latin-9 converter.
package u2l9_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int ACC_W  = 31;
	localparam int PEND_W = 3;

	localparam logic [ACC_W-1:0] CP_OE_UPPER = 31'h0152;
	localparam logic [ACC_W-1:0] CP_OE_LOWER = 31'h0153;
	localparam logic [ACC_W-1:0] CP_S_CARON  = 31'h0160;
	localparam logic [ACC_W-1:0] CP_s_CARON  = 31'h0161;
	localparam logic [ACC_W-1:0] CP_Y_DIAER  = 31'h0178;
	localparam logic [ACC_W-1:0] CP_Z_CARON  = 31'h017D;
	localparam logic [ACC_W-1:0] CP_z_CARON  = 31'h017E;
	localparam logic [ACC_W-1:0] CP_EURO     = 31'h20AC;

	localparam logic [7:0] L9_OE_UPPER = 8'd188;
	localparam logic [7:0] L9_OE_LOWER = 8'd189;
	localparam logic [7:0] L9_S_CARON  = 8'd166;
	localparam logic [7:0] L9_s_CARON  = 8'd168;
	localparam logic [7:0] L9_Y_DIAER  = 8'd190;
	localparam logic [7:0] L9_Z_CARON  = 8'd180;
	localparam logic [7:0] L9_z_CARON  = 8'd184;
	localparam logic [7:0] L9_EURO     = 8'd164;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} u2l9_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        end_marker;
		logic [15:0] out_length;
	} u2l9_out_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       last;
	} u2l9_req_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] data;
	} u2l9_map_t;

	function automatic u2l9_map_t latin9_map(input logic [ACC_W-1:0] cp);
		u2l9_map_t m;
		m.hit  = 1'b1;
		m.data = cp[7:0];
		if (cp[ACC_W-1:8] != '0) begin
			case (cp)
				CP_OE_UPPER: m.data = L9_OE_UPPER;
				CP_OE_LOWER: m.data = L9_OE_LOWER;
				CP_S_CARON:  m.data = L9_S_CARON;
				CP_s_CARON:  m.data = L9_s_CARON;
				CP_Y_DIAER:  m.data = L9_Y_DIAER;
				CP_Z_CARON:  m.data = L9_Z_CARON;
				CP_z_CARON:  m.data = L9_z_CARON;
				CP_EURO:     m.data = L9_EURO;
				default: begin
					m.hit  = 1'b0;
					m.data = 8'd0;
				end
			endcase
		end
		return m;
	endfunction

endpackage

@@ sv/u2l9_front.sv @@
// Front end: UTF-8 sequence decode and Latin-9 classification, one byte per cycle while the queue is not full.
module u2l9_front import u2l9_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  u2l9_in_t  in_data,
	input  logic      q_full,
	output logic      push,
	output u2l9_req_t push_req
);

	logic [PEND_W-1:0] pend_q, pend_n;
	logic [ACC_W-1:0]  acc_q, acc_n;
	logic              inv_q, inv_n;
	logic [7:0]        b;
	u2l9_map_t         m;
	logic              take;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;
	assign b        = in_data.in_byte;

	always_comb begin
		pend_n        = pend_q;
		acc_n         = acc_q;
		inv_n         = inv_q;
		m             = '0;
		push_req.emit = 1'b0;
		push_req.data = b;
		push_req.last = in_data.is_last;
		if (pend_q != '0) begin
			inv_n  = inv_q | (b[7:6] != 2'b10);
			acc_n  = {acc_q[ACC_W-7:0], b[5:0]};
			pend_n = pend_q - 1'b1;
			m      = latin9_map(acc_n);
			if (pend_n == '0 && !inv_n) begin
				push_req.emit = m.hit;
				push_req.data = m.data;
			end
		end else begin
			case (b) inside
				[8'h00:8'h7F]: push_req.emit = 1'b1;
				[8'hC0:8'hDF]: begin
					inv_n  = 1'b0;
					pend_n = 3'd1;
					acc_n  = {26'd0, b[4:0]};
				end
				[8'hE0:8'hEF]: begin
					inv_n  = 1'b0;
					pend_n = 3'd2;
					acc_n  = {27'd0, b[3:0]};
				end
				[8'hF0:8'hF7]: begin
					inv_n  = 1'b0;
					pend_n = 3'd3;
					acc_n  = {28'd0, b[2:0]};
				end
				[8'hF8:8'hFB]: begin
					inv_n  = 1'b0;
					pend_n = 3'd4;
					acc_n  = {29'd0, b[1:0]};
				end
				[8'hFC:8'hFD]: begin
					inv_n  = 1'b0;
					pend_n = 3'd5;
					acc_n  = {30'd0, b[0]};
				end
				default: ;
			endcase
		end
		if (in_data.is_last) begin
			pend_n = '0;
			acc_n  = '0;
			inv_n  = 1'b0;
		end
	end

	assign push = take && (push_req.emit || push_req.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			acc_q  <= '0;
			inv_q  <= 1'b0;
		end else if (take) begin
			pend_q <= pend_n;
			acc_q  <= acc_n;
			inv_q  <= inv_n;
		end
	end

endmodule

@@ sv/u2l9_queue.sv @@
// Short request queue between the decode front end and the output back end.
module u2l9_queue import u2l9_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  u2l9_req_t push_req,
	input  logic      pop,
	output logic      full,
	output logic      head_valid,
	output u2l9_req_t head
);

	u2l9_req_t         mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("request pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("request popped from empty queue");
`endif

endmodule

@@ sv/u2l9_back.sv @@
// Back end: output counting, end marker expansion and the output register.
module u2l9_back import u2l9_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  u2l9_req_t head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output u2l9_out_t out_data
);

	logic [LENGTH_BITS-1:0]    cnt_q, cnt_inc;
	logic [LENGTH_BITS+15:0]   inc_ext, cnt_ext;
	logic                      end_pend_q;
	logic                      load;
	logic                      send_end;
	logic                      out_valid_q;
	u2l9_out_t                 out_q;

	assign load     = head_valid && (!out_valid_q || out_ready);
	assign send_end = end_pend_q || !head.emit;
	assign cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign inc_ext  = {16'd0, cnt_inc};
	assign cnt_ext  = {16'd0, cnt_q};
	assign pop      = load && (send_end || !head.last);

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_end) begin
				out_q.out_byte   <= 8'd0;
				out_q.end_marker <= 1'b1;
				out_q.out_length <= cnt_ext[15:0];
			end else begin
				out_q.out_byte   <= head.data;
				out_q.end_marker <= 1'b0;
				out_q.out_length <= inc_ext[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			end_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (send_end) begin
					cnt_q      <= '0;
					end_pend_q <= 1'b0;
				end else begin
					cnt_q      <= cnt_inc;
					end_pend_q <= head.last;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_end_pend_head: assert property (@(posedge clk) disable iff (!arst_n)
		end_pend_q |-> head_valid && head.emit && head.last)
		else $error("pending end marker without its request at the head");
	a_cnt_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load && send_end |=> cnt_q == '0)
		else $error("length count not cleared after end marker");
	a_pop_only_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> load) else $error("request dropped without a result");
`endif

endmodule

@@ sv/utf8_to_latin9_stream.sv @@
// Top level of the UTF-8 to ISO-8859-15 (Latin-9) stream converter.
// Takes one UTF-8 byte per cycle while the queue is not full and gives one result
// per cycle while out_ready is high: each byte is decoded combinationally by the
// front end, written into the request queue when accepted, and then loaded into
// the output register once that register is free. A byte that carries is_last
// and also completes a character yields two results, the character and the end
// marker, so its request stays at the queue head until both are loaded; the queue
// of four entries buffers that and short output stalls; in_ready drops while full.
// The output length counts bytes emitted in the current string and saturates at
// 2^LENGTH_BITS - 1; the end marker result carries the final count and out_byte 0.
module utf8_to_latin9_stream import u2l9_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  u2l9_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output u2l9_out_t out_data
);

	logic      q_full;
	logic      push;
	u2l9_req_t push_req;
	logic      pop;
	logic      head_valid;
	u2l9_req_t head;

	u2l9_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_req (push_req)
	);

	u2l9_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_req   (push_req),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	u2l9_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

@@ test/utf8_to_latin9_stream_test.sv @@
// Self-checking testbench for the UTF-8 to Latin-9 stream converter.
module utf8_to_latin9_stream_test;
	timeunit 1ns;
	timeprecision 1ps;
	import u2l9_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	u2l9_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	u2l9_out_t out_data;

	u2l9_out_t    latin9_queue[$];
	logic [7:0]   str_buf[$];

	logic [2:0]   pend_cnt = '0;
	logic [30:0]  code_acc = '0;
	logic         seq_bad  = 1'b0;
	logic [15:0]  emit_cnt = '0;

	int fault_count  = 0;
	int bytes_sent   = 0;
	int strings_sent = 0;
	int results_seen = 0;
	int cycle_count  = 0;
	int burst_left   = 0;
	bit gaps_on      = 1'b1;
	int hold_req     = 0;
	int hold_left    = 0;
	int stall_mode   = 0;
	logic [5:0]  stall_phase = '0;
	logic [31:0] pat_a = '1;
	logic [31:0] pat_b = '1;

	utf8_to_latin9_stream DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [8:0] latin9_of(input logic [30:0] cp);
		if (cp < 31'd256)
			return {1'b0, cp[7:0]};
		case (cp)
			CP_OE_UPPER: return {1'b0, L9_OE_UPPER};
			CP_OE_LOWER: return {1'b0, L9_OE_LOWER};
			CP_S_CARON:  return {1'b0, L9_S_CARON};
			CP_s_CARON:  return {1'b0, L9_s_CARON};
			CP_Y_DIAER:  return {1'b0, L9_Y_DIAER};
			CP_Z_CARON:  return {1'b0, L9_Z_CARON};
			CP_z_CARON:  return {1'b0, L9_z_CARON};
			CP_EURO:     return {1'b0, L9_EURO};
			default:     return 9'h100;
		endcase
	endfunction

	task automatic note_latin9(input logic [7:0] v);
		if (emit_cnt != 16'hFFFF)
			emit_cnt++;
		latin9_queue.push_back('{out_byte: v, end_marker: 1'b0, out_length: emit_cnt});
	endtask

	task automatic decode_utf8(input logic [7:0] b, input logic l);
		logic [8:0] m;
		if (pend_cnt != 0) begin
			if (b[7:6] != 2'b10)
				seq_bad = 1'b1;
			code_acc = {code_acc[24:0], b[5:0]};
			pend_cnt--;
			if (pend_cnt == 0 && !seq_bad) begin
				m = latin9_of(code_acc);
				if (!m[8])
					note_latin9(m[7:0]);
			end
		end else if (!b[7]) begin
			note_latin9(b);
		end else if (b[7:6] == 2'b11 && b < 8'hFE) begin
			seq_bad = 1'b0;
			if (b < 8'hE0) begin
				pend_cnt = 3'd1;
				code_acc = 31'(b & 8'h1F);
			end else if (b < 8'hF0) begin
				pend_cnt = 3'd2;
				code_acc = 31'(b & 8'h0F);
			end else if (b < 8'hF8) begin
				pend_cnt = 3'd3;
				code_acc = 31'(b & 8'h07);
			end else if (b < 8'hFC) begin
				pend_cnt = 3'd4;
				code_acc = 31'(b & 8'h03);
			end else begin
				pend_cnt = 3'd5;
				code_acc = 31'(b & 8'h01);
			end
		end
		if (l) begin
			latin9_queue.push_back('{out_byte: 8'h00, end_marker: 1'b1, out_length: emit_cnt});
			pend_cnt = '0;
			code_acc = '0;
			seq_bad  = 1'b0;
			emit_cnt = '0;
		end
	endtask

	task automatic send_req(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gaps_on && gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= '{in_byte: b, is_last: l};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_utf8(b, l);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_string();
		for (int i = 0; i < str_buf.size(); i++)
			send_req(str_buf[i], i == str_buf.size() - 1);
		str_buf.delete();
		strings_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (latin9_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_single_bytes();
		str_buf = '{8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF};
		send_string();
	endtask

	task automatic test_latin9_map();
		str_buf = '{8'hC5, 8'h92, 8'hC5, 8'h93, 8'hC5, 8'hA0, 8'hC5, 8'hA1, 8'hC5, 8'hB8,
			8'hC5, 8'hBD, 8'hC5, 8'hBE, 8'hE2, 8'h82, 8'hAC};
		send_string();
	endtask

	task automatic test_broken_sequences();
		// lead inside a sequence, six-byte overlong 'i', then a truncated tail
		str_buf = '{8'hC3, 8'hC3, 8'hFC, 8'h80, 8'h80, 8'h80, 8'h81, 8'hA9, 8'hE2, 8'h82};
		send_string();
		str_buf = '{8'hA9, 8'h41};
		send_string();
	endtask

	task automatic test_receiver_hold();
		hold_req = 250;
		gaps_on  = 1'b0;
		for (int i = 0; i < 60; i++)
			str_buf.push_back(8'($urandom_range(0, 127)));
		str_buf.push_back(8'hC5);
		str_buf.push_back(8'hA1);
		send_string();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_strings(input int target);
		int          first_sent;
		int          n_chars;
		int          kind;
		int          nb;
		int          k;
		int          bits;
		int          idx;
		int          top;
		logic [30:0] cp;
		logic [7:0]  lead_mark;
		logic        cut;
		first_sent = bytes_sent;
		gaps_on = 1'b1;
		while (bytes_sent - first_sent < target) begin
			n_chars = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
			cut = 1'b0;
			for (int c = 0; c < n_chars && !cut; c++) begin
				kind = $urandom_range(0, 99);
				nb = 0;
				cp = '0;
				if (kind < 35) begin
					str_buf.push_back(8'($urandom_range(0, 127)));
				end else if (kind < 55) begin
					nb = 2;
					cp = 31'($urandom_range(0, 'h7FF));
				end else if (kind < 70) begin
					case ($urandom_range(0, 7))
						0: cp = CP_OE_UPPER;
						1: cp = CP_OE_LOWER;
						2: cp = CP_S_CARON;
						3: cp = CP_s_CARON;
						4: cp = CP_Y_DIAER;
						5: cp = CP_Z_CARON;
						6: cp = CP_z_CARON;
						default: cp = CP_EURO;
					endcase
					nb = ((cp == CP_EURO) ? 3 : 2) + (($urandom_range(0, 3) == 0) ? 1 : 0);
				end else if (kind < 84) begin
					nb = $urandom_range(3, 6);
					cp = 31'($urandom);
					if ($urandom_range(0, 1) == 1)
						cp = cp & 31'hFF;
				end else if (kind < 90) begin
					str_buf.push_back(8'($urandom_range(0, 255)));
				end else begin
					nb = $urandom_range(2, 6);
					cp = 31'($urandom);
					cut = (kind >= 95);
				end
				if (nb != 0) begin
					bits = 5 * nb + 1;
					cp = cp & ((31'h1 << bits) - 31'h1);
					lead_mark = 8'hFF << (8 - nb);
					str_buf.push_back(lead_mark | 8'(cp >> (6 * (nb - 1))));
					k = cut ? $urandom_range(0, nb - 2) : nb - 1;
					for (int j = nb - 2; j >= nb - 1 - k; j--)
						str_buf.push_back(8'h80 | (8'(cp >> (6 * j)) & 8'h3F));
					if (kind >= 90 && kind < 95) begin
						// corrupt one continuation
						idx = str_buf.size() - 1 - $urandom_range(0, nb - 2);
						top = $urandom_range(0, 2);
						if (top == 2)
							top = 3;
						str_buf[idx] = {2'(top), 6'($urandom_range(0, 63))};
					end
				end
			end
			send_string();
		end
	endtask

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				stall_mode = $urandom_range(0, 3);
				pat_a = $urandom;
				pat_b = $urandom;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= pat_a[stall_phase[4:0]] | pat_b[stall_phase[4:0]];
				2: out_ready <= pat_a[stall_phase[4:0]];
				default: out_ready <= pat_a[stall_phase[4:0]] & pat_b[stall_phase[4:0]];
			endcase
			stall_phase <= stall_phase + 6'd1;
		end
	end

	always @(posedge clk) begin
		u2l9_out_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (latin9_queue.size() == 0) begin
				$error("unexpected result: out_byte %02h end_marker %0b out_length %0d",
					out_data.out_byte, out_data.end_marker, out_data.out_length);
				fault_count++;
			end else begin
				want = latin9_queue.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
					fault_count++;
				end
				if (out_data.end_marker !== want.end_marker) begin
					$error("end_marker: expected %0b, got %0b",
						want.end_marker, out_data.end_marker);
					fault_count++;
				end
				if (out_data.out_length !== want.out_length) begin
					$error("out_length: expected %0d, got %0d",
						want.out_length, out_data.out_length);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, latin9_queue.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_bytes();
		wait_drained();
		test_latin9_map();
		wait_drained();
		test_broken_sequences();
		wait_drained();
		test_receiver_hold();
		wait_drained();
		test_random_strings(1850);
		wait_drained();
		repeat (16) @(posedge clk);
		$display("Covered %0d bytes in %0d strings, %0d results checked in %0d cycles",
			bytes_sent, strings_sent, results_seen, cycle_count);
		$display("incl. Latin-9 mapping, broken and truncated sequences, long output hold");
		if (fault_count == 0 && latin9_queue.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/u2l9_pkg.sv
sv/u2l9_front.sv
sv/u2l9_queue.sv
sv/u2l9_back.sv
sv/utf8_to_latin9_stream.sv
test/utf8_to_latin9_stream_test.sv
